// File: hdl/rbrt_pkg.sv
// Package for the receive block ring tracker: payload types, codes and constants.
`default_nettype none
package rbrt_pkg;

  // Default sizes, handed to the top level parameters
  localparam int MAX_BLOCKS_DEF = 64;
  localparam int ISO_GROUP_DEF  = 16;

  // Configuration port
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  // Register indexes (word address)
  localparam logic [1:0] REG_BLOCK_COUNT = 2'd0;
  localparam logic [1:0] REG_UNIT_SIZE   = 2'd1;
  localparam logic [1:0] REG_ISO_MODE    = 2'd2;

  // Register reset values
  localparam logic [6:0]  BLOCK_COUNT_RST = 7'd64;
  localparam logic [15:0] UNIT_SIZE_RST   = 16'd512;

  // Action codes
  localparam logic [2:0] ACT_SUBMIT   = 3'd0;
  localparam logic [2:0] ACT_COMPLETE = 3'd1;
  localparam logic [2:0] ACT_READ     = 3'd2;
  localparam logic [2:0] ACT_FLUSH    = 3'd3;
  localparam logic [2:0] ACT_PEEK     = 3'd4;

  // Result status codes
  localparam logic [1:0] RS_OK    = 2'd0;
  localparam logic [1:0] RS_EMPTY = 2'd1;
  localparam logic [1:0] RS_RANGE = 2'd2;
  localparam logic [1:0] RS_CLAMP = 2'd3;

  // Block status word
  localparam int          ENT_W    = 18;
  localparam logic [17:0] ENT_FREE = 18'h3FFFF;
  localparam logic [17:0] ENT_BUSY = 18'h3FFFE;

  typedef struct packed {
    logic [2:0]  action;
    logic [5:0]  block_index;
    logic        packet_ok;
    logic [15:0] received_length;
  } rbrt_cmd_t;

  typedef struct packed {
    logic [5:0]  result_block;
    logic [15:0] data_length;
    logic [1:0]  result_status;
  } rbrt_res_t;

  typedef struct packed {
    logic [6:0]  block_count;
    logic [15:0] unit_size;
    logic        iso_mode;
  } rbrt_cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic sub_init;
    logic sub_wr;
    logic cmp_wr;
    logic srch_init;
    logic srch_chk;
    logic free_pop;
    logic free_push;
  } rbrt_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] action;
    logic       oor;
    logic       sub_last;
    logic       found;
    logic       readable;
  } rbrt_sts_t;

endpackage
`default_nettype wire

// File: hdl/rbrt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module rbrt_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hdl/rbrt_cfg.sv
// Configuration registers behind the APB-style port.
`default_nettype none
module rbrt_cfg
  import rbrt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output rbrt_cfg_t              cfg
);

  logic       wr_beat;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_beat = psel & penable & pwrite;
  assign reg_idx = paddr[APB_AW-1:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_count <= BLOCK_COUNT_RST;
      cfg.unit_size   <= UNIT_SIZE_RST;
      cfg.iso_mode    <= 1'b0;
    end else if (wr_beat) begin
      case (reg_idx)
        REG_BLOCK_COUNT: cfg.block_count <= pwdata[6:0];
        REG_UNIT_SIZE:   cfg.unit_size   <= pwdata[15:0];
        REG_ISO_MODE:    cfg.iso_mode    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_BLOCK_COUNT: prdata = {25'd0, cfg.block_count};
      REG_UNIT_SIZE:   prdata = {16'd0, cfg.unit_size};
      REG_ISO_MODE:    prdata = {31'd0, cfg.iso_mode};
      default:         prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/rbrt_ctrl.sv
// Sequencer for submit, complete and the read/flush/peek search.
`default_nettype none
module rbrt_ctrl
  import rbrt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire rbrt_sts_t sts,
  output rbrt_ctl_t      ctl,
  output logic           busy,
  output logic           done
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SUB_INIT,
    S_SUB_WR,
    S_CMP,
    S_SRCH_INIT,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_FREE_POP,
    S_FREE_PUSH,
    S_DONE
  } state_t;

  state_t state, state_next;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (sts.action)
          ACT_SUBMIT:   state_next = S_SUB_INIT;
          ACT_COMPLETE: state_next = S_CMP;
          ACT_READ,
          ACT_FLUSH,
          ACT_PEEK:     state_next = S_SRCH_INIT;
          default:      state_next = S_DONE;
        endcase
      end
      S_SUB_INIT: state_next = S_SUB_WR;
      S_SUB_WR: begin
        if (sts.sub_last) state_next = S_DONE;
      end
      S_CMP: state_next = S_DONE;
      S_SRCH_INIT: begin
        state_next = sts.oor ? S_DONE : S_SRCH_RD;
      end
      S_SRCH_RD: state_next = S_SRCH_CHK;
      S_SRCH_CHK: begin
        if (!sts.found) begin
          state_next = S_SRCH_RD;
        end else if (sts.readable &&
                     (sts.action == ACT_READ || sts.action == ACT_FLUSH)) begin
          state_next = S_FREE_POP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_FREE_POP: begin
        state_next = (sts.action == ACT_FLUSH) ? S_FREE_PUSH : S_DONE;
      end
      S_FREE_PUSH: state_next = S_DONE;
      S_DONE:      state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // state and registered handshake outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
      done  <= (state_next == S_DONE);
    end
  end

  // datapath commands
  always_comb begin
    ctl           = '0;
    ctl.load      = (state == S_IDLE) && start;
    ctl.sub_init  = (state == S_SUB_INIT);
    ctl.sub_wr    = (state == S_SUB_WR);
    ctl.cmp_wr    = (state == S_CMP);
    ctl.srch_init = (state == S_SRCH_INIT);
    ctl.srch_chk  = (state == S_SRCH_CHK);
    ctl.free_pop  = (state == S_FREE_POP);
    ctl.free_push = (state == S_FREE_PUSH);
  end

endmodule
`default_nettype wire

// File: hdl/rbrt_dp.sv
// Datapath: ring indexes, block status store, clamp and result register.
`default_nettype none
module rbrt_dp
  import rbrt_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int ISO_GROUP  = ISO_GROUP_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire rbrt_cfg_t cfg,
  input  wire rbrt_cmd_t cmd,
  input  wire rbrt_ctl_t ctl,
  output rbrt_sts_t      sts,
  output rbrt_res_t      result
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int NW = $clog2(MAX_BLOCKS + 1);
  localparam int CW = $clog2(ISO_GROUP + 1);

  rbrt_cmd_t           cmd_q;
  logic [IW-1:0]       push_idx;
  logic [IW-1:0]       pop_idx;
  logic [IW-1:0]       cur;
  logic [CW-1:0]       cnt;
  logic [MAX_BLOCKS-1:0] vld;
  logic                rd_vld;
  logic [ENT_W-1:0]    rd_data;

  logic [NW-1:0]       ring_n;
  logic [IW-1:0]       cur_next;
  logic [IW-1:0]       base;
  logic [IW-1:0]       push_new;
  logic [31:0]         grp;
  logic [31:0]         push_sum;
  logic [ENT_W-1:0]    ent;
  logic                ent_nz;
  logic                ent_rd;
  logic                wrap;
  logic                bidx_ok;
  logic [15:0]         cmp_len;
  logic [1:0]          cmp_stat;

  logic                we;
  logic [IW-1:0]       waddr;
  logic [ENT_W-1:0]    wdata;

  // effective ring length
  always_comb begin
    if (cfg.block_count == '0) begin
      ring_n = NW'(1);
    end else if (32'(cfg.block_count) > MAX_BLOCKS) begin
      ring_n = NW'(MAX_BLOCKS);
    end else begin
      ring_n = NW'(cfg.block_count);
    end
  end

  // cursor advance with wrap
  assign cur_next = ((NW'(cur) + NW'(1)) < ring_n) ? cur + IW'(1) : '0;

  // submit group start and the push index after it
  assign base     = (NW'(push_idx) < ring_n) ? push_idx : '0;
  assign grp      = cfg.iso_mode ? 32'(ISO_GROUP) : 32'd1;
  assign push_sum = 32'(base) + grp;
  assign push_new = (push_sum < 32'(ring_n)) ? IW'(push_sum) : '0;

  // search decode of the entry just read
  assign ent    = rd_vld ? rd_data : ENT_FREE;
  assign ent_nz = (ent != '0);
  assign ent_rd = ent_nz && (ent[ENT_W-1:16] == '0);
  assign wrap   = (cur_next == pop_idx);

  // completion length clamp
  assign bidx_ok = (32'(cmd_q.block_index) < MAX_BLOCKS);
  always_comb begin
    cmp_len  = '0;
    cmp_stat = RS_OK;
    if (cmd_q.packet_ok) begin
      if (cmd_q.received_length > cfg.unit_size) begin
        cmp_len  = cfg.unit_size;
        cmp_stat = RS_CLAMP;
      end else begin
        cmp_len = cmd_q.received_length;
      end
    end
  end

  // status back to the controller
  always_comb begin
    sts.action   = cmd_q.action;
    sts.oor      = (NW'(pop_idx) >= ring_n);
    sts.sub_last = ((32'(cnt) + 32'd1) == grp);
    sts.found    = ent_nz || wrap;
    sts.readable = ent_rd;
  end

  // store write port
  always_comb begin
    we    = 1'b0;
    waddr = cur;
    wdata = ENT_FREE;
    if (ctl.sub_wr) begin
      we    = 1'b1;
      wdata = ENT_BUSY;
    end else if (ctl.cmp_wr) begin
      we    = bidx_ok;
      waddr = IW'(cmd_q.block_index);
      wdata = {2'b00, cmp_len};
    end else if (ctl.free_pop) begin
      we = 1'b1;
    end else if (ctl.free_push) begin
      we    = 1'b1;
      waddr = push_idx;
    end
  end

  rbrt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_BLOCKS)
  ) u_status_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (cur),
    .rdata (rd_data)
  );

  // valid bits: an entry never written reads as free
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (we) vld[waddr] <= 1'b1;
      rd_vld <= vld[cur];
    end
  end

  // ring indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      push_idx <= '0;
      pop_idx  <= '0;
    end else begin
      if (ctl.sub_wr && sts.sub_last) push_idx <= push_new;
      if (ctl.srch_init && sts.oor) pop_idx <= '0;
      if (ctl.srch_chk) begin
        if (ent_nz) pop_idx <= cur;
        else if (wrap) pop_idx <= cur_next;
      end
      if (ctl.free_pop) begin
        if (cmd_q.action == ACT_FLUSH) pop_idx <= push_idx;
        else pop_idx <= cur_next;
      end
    end
  end

  // item, cursor, group counter and result
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q  <= cmd;
      result <= '0;
    end
    if (ctl.sub_init) begin
      cur    <= base;
      cnt    <= '0;
      result <= '{result_block: 6'(base), data_length: '0, result_status: RS_OK};
    end
    if (ctl.sub_wr) begin
      cur <= cur_next;
      cnt <= cnt + CW'(1);
    end
    if (ctl.cmp_wr) begin
      result <= '{result_block: cmd_q.block_index, data_length: cmp_len,
                  result_status: cmp_stat};
    end
    if (ctl.srch_init) begin
      if (sts.oor) begin
        result <= '{result_block: '0, data_length: '0, result_status: RS_RANGE};
      end else begin
        cur <= pop_idx;
      end
    end
    if (ctl.srch_chk) begin
      if (ent_nz) begin
        result <= '{result_block: 6'(cur),
                    data_length: ent_rd ? ent[15:0] : 16'd0,
                    result_status: ent_rd ? RS_OK : RS_EMPTY};
      end else begin
        cur <= cur_next;
        if (wrap) begin
          result <= '{result_block: 6'(cur_next), data_length: '0,
                      result_status: RS_EMPTY};
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/receive_block_ring_tracker_top.sv
// Top level of the receive block ring tracker.
//
//  channel   signals                                  direction  handshake
//  config    psel penable pwrite paddr pwdata prdata  in/out     write at psel&penable&pwrite
//  command   start cmd busy                           in/out     beat when start & !busy
//  result    done result                              out        one-cycle strobe on done
//
// From the accepting edge to the done strobe: submit decodes, sets up, then
// writes its group (1 bulk, ISO_GROUP isochronous), one block status write a
// cycle; complete decodes and writes its entry; read, flush and peek decode,
// set up the skip search, read and check one status RAM entry per ring entry
// visited; a read or flush that frees a block adds a pop step, a flush also a push step.
// busy falls the cycle after done. Reset is synchronous and returns every block to free
// at once through per-entry valid bits; results are not held off by the receiver.
`default_nettype none
module receive_block_ring_tracker_top
  import rbrt_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int ISO_GROUP  = ISO_GROUP_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  input  wire logic              start,
  input  wire rbrt_cmd_t         cmd,
  output logic                   busy,
  output logic                   done,
  output rbrt_res_t              result
);

  rbrt_cfg_t cfg;
  rbrt_ctl_t ctl;
  rbrt_sts_t sts;

  rbrt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rbrt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  rbrt_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .ISO_GROUP  (ISO_GROUP)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .cmd    (cmd),
    .ctl    (ctl),
    .sts    (sts),
    .result (result)
  );

endmodule
`default_nettype wire
